FILE: src/mba_pkg.sv
package mba_pkg;

    localparam int SUM_W    = 24;
    localparam int CNT_W    = 16;
    localparam int PIX_W    = 8;
    localparam int CFG_W    = 11;
    localparam int CADDR_W  = 2;
    localparam int PHASES   = 6;
    localparam int TALL_ROWS = 600;

    localparam logic [CADDR_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CADDR_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CADDR_W-1:0] CFG_EFFECT_PHASE  = 2'd2;
    localparam logic [CADDR_W-1:0] CFG_DIRECTION_IN  = 2'd3;

    typedef logic [SUM_W-1:0] t_sum;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       in_source;
    } t_in;

    typedef struct packed {
        logic [7:0] block_col;
        logic [7:0] block_row;
        logic [7:0] block_edge;
        logic [7:0] avg_red;
        logic [7:0] avg_green;
        logic [7:0] avg_blue;
        logic       frame_done;
    } t_out;

    // one entry of the per-column accumulator store
    typedef struct packed {
        t_sum red;
        t_sum green;
        t_sum blue;
        t_cnt count;
    } t_acc;

    localparam logic [7:0] EDGE_SHORT [PHASES] = '{8'd160, 8'd80, 8'd40, 8'd20, 8'd10, 8'd5};
    localparam logic [7:0] EDGE_TALL  [PHASES] = '{8'd200, 8'd100, 8'd50, 8'd25, 8'd10, 8'd5};

    // block edge from table row, phase and direction
    function automatic logic [7:0] block_edge_of(
        input logic       tall,
        input logic [2:0] phase,
        input logic       dir_in
    );
        logic [2:0] ph;
        logic [2:0] idx;
        ph  = (phase > 3'(PHASES - 1)) ? 3'(PHASES - 1) : phase;
        idx = dir_in ? ph : 3'(PHASES - 1) - ph;
        return tall ? EDGE_TALL[idx] : EDGE_SHORT[idx];
    endfunction

endpackage

FILE: src/mba_div.sv
module mba_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  mba_pkg::t_sum i_sum_r,
    input  mba_pkg::t_sum i_sum_g,
    input  mba_pkg::t_sum i_sum_b,
    input  mba_pkg::t_cnt i_count,
    output logic          o_done,
    output logic [7:0]    o_quot_r,
    output logic [7:0]    o_quot_g,
    output logic [7:0]    o_quot_b
);
    import mba_pkg::*;

    // quotient always fits 8 bits: each sum is at most 255 times its count
    t_sum       r_rem  [3];
    logic [7:0] r_quot [3];
    t_sum       r_dsh;
    logic [2:0] r_step;
    logic       r_busy;
    logic       r_done;
    logic       r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == 3'd7);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_step == 3'd7) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem[0] <= i_sum_r;
            r_rem[1] <= i_sum_g;
            r_rem[2] <= i_sum_b;
            for (int l = 0; l < 3; l++) begin
                r_quot[l] <= '0;
            end
            r_dsh  <= {1'b0, i_count, 7'b0};
            r_step <= '0;
            r_zero <= (i_count == '0);
        end else if (r_busy) begin
            // one restoring step per lane, most significant quotient bit first
            for (int l = 0; l < 3; l++) begin
                if (r_rem[l] >= r_dsh) begin
                    r_rem[l]  <= r_rem[l] - r_dsh;
                    r_quot[l] <= {r_quot[l][6:0], 1'b1};
                end else begin
                    r_quot[l] <= {r_quot[l][6:0], 1'b0};
                end
            end
            r_dsh  <= r_dsh >> 1;
            r_step <= r_step + 3'd1;
        end
    end

    assign o_done   = r_done;
    assign o_quot_r = r_zero ? 8'd0 : r_quot[0];
    assign o_quot_g = r_zero ? 8'd0 : r_quot[1];
    assign o_quot_b = r_zero ? 8'd0 : r_quot[2];

endmodule

FILE: src/mosaic_block_averager_core.sv
// Each pixel is accepted, then its column entry gets a read-modify-write; no new pixel is
// accepted until that write-back is done. A pixel that ends a block goes through accept,
// write-back, 8 divider steps, the divider's done flag, and the load of the output
// register (held while full).
// Reset (synchronous, active low) restores register defaults, zeroes the position and
// clears all per-column valid bits at once; every register write restarts the frame.
module mosaic_block_averager_core #(
    parameter int MAX_WIDTH      = 1024,
    parameter int MAX_HEIGHT     = 1024,
    parameter int MAX_BLOCK_COLS = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  mba_pkg::t_in                   i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output mba_pkg::t_out                  o_data,
    input  logic                           i_cfg_we,
    input  logic [mba_pkg::CADDR_W-1:0]    i_cfg_addr,
    input  logic [mba_pkg::CFG_W-1:0]      i_cfg_data
);
    import mba_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int SW = $clog2(MAX_BLOCK_COLS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // configuration
    logic [CFG_W-1:0] r_screen_width;
    logic [CFG_W-1:0] r_screen_height;
    logic [2:0]       r_effect_phase;
    logic             r_direction_in;

    // raster position and block position of the next pixel
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [7:0]    r_ox;
    logic [7:0]    r_oy;
    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;
    logic [SW-1:0] r_slot;

    // the item in flight
    logic [1:0]    r_state;
    t_in           r_pix;
    logic [SW-1:0] r_cur_slot;
    logic [7:0]    r_cur_col;
    logic [7:0]    r_cur_row;
    logic          r_blk_end;
    logic          r_frame_end;

    // accumulator store: one entry per block column, valid bits stand for the zero reset
    t_acc                    mem [MAX_BLOCK_COLS];
    t_acc                    r_rd;
    logic                    r_rd_ok;
    logic [MAX_BLOCK_COLS-1:0] r_ok;

    logic          r_out_valid;
    t_out          r_out;

    logic [7:0]    bs;
    logic [7:0]    bs_m1;
    logic [XW-1:0] w_m1;
    logic [YW-1:0] h_m1;
    logic          accept;
    logic          out_free;
    logic          x_end;
    logic          y_end;
    t_acc          acc;
    logic          div_start;
    logic          div_done;
    logic [7:0]    q_r;
    logic [7:0]    q_g;
    logic [7:0]    q_b;

    // clamp a dimension register to 1..max; the caller subtracts one for the last index
    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned mx);
        int unsigned vi;
        vi = {21'b0, v};
        if (vi == 0) begin
            return 1;
        end
        return (vi > mx) ? mx : vi;
    endfunction

    assign w_m1  = XW'(clamp_dim(r_screen_width, MAX_WIDTH) - 1);
    assign h_m1  = YW'(clamp_dim(r_screen_height, MAX_HEIGHT) - 1);
    assign bs    = block_edge_of(r_screen_height == CFG_W'(TALL_ROWS), r_effect_phase,
                                 r_direction_in);
    assign bs_m1 = bs - 8'd1;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign x_end    = (r_x == w_m1);
    assign y_end    = (r_y == h_m1);

    // configuration and raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= CFG_W'(800);
            r_screen_height <= CFG_W'(600);
            r_effect_phase  <= '0;
            r_direction_in  <= 1'b0;
            r_x    <= '0;
            r_y    <= '0;
            r_ox   <= '0;
            r_oy   <= '0;
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                CFG_EFFECT_PHASE:  r_effect_phase  <= i_cfg_data[2:0];
                CFG_DIRECTION_IN:  r_direction_in  <= i_cfg_data[0];
                default: ;
            endcase
            // restart the frame
            r_x    <= '0;
            r_y    <= '0;
            r_ox   <= '0;
            r_oy   <= '0;
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (accept) begin
            if (x_end) begin
                // wrap to the start of the next row, or of the next frame
                r_x    <= '0;
                r_ox   <= '0;
                r_col  <= '0;
                r_slot <= '0;
                if (y_end) begin
                    r_y   <= '0;
                    r_oy  <= '0;
                    r_row <= '0;
                end else begin
                    r_y <= r_y + YW'(1);
                    if (r_oy == bs_m1) begin
                        r_oy  <= '0;
                        r_row <= r_row + YW'(1);
                    end else begin
                        r_oy <= r_oy + 8'd1;
                    end
                end
            end else begin
                r_x <= r_x + XW'(1);
                if (r_ox == bs_m1) begin
                    r_ox   <= '0;
                    r_col  <= r_col + XW'(1);
                    r_slot <= (r_slot == SW'(MAX_BLOCK_COLS - 1)) ? '0 : r_slot + SW'(1);
                end else begin
                    r_ox <= r_ox + 8'd1;
                end
            end
        end
    end

    // capture the accepted item and where it falls
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix       <= i_data;
            r_cur_slot  <= r_slot;
            r_cur_col   <= 8'(r_col);
            r_cur_row   <= 8'(r_row);
            r_blk_end   <= ((r_ox == bs_m1) || x_end) && ((r_oy == bs_m1) || y_end);
            r_frame_end <= x_end && y_end;
        end
    end

    // read the column entry on accept; the write back happens in S_CALC
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= mem[r_slot];
        end
        if (r_state == S_CALC) begin
            mem[r_cur_slot] <= r_blk_end ? t_acc'('0) : acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_ok <= '0;
        end else if (r_state == S_CALC) begin
            r_ok[r_cur_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_ok <= r_ok[r_slot];
        end
    end

    // add the pixel to the entry; an entry never written since restart reads as zero
    always_comb begin
        acc = r_rd_ok ? r_rd : t_acc'('0);
        if (r_pix.in_source) begin
            acc.red   = acc.red   + SUM_W'(r_pix.red);
            acc.green = acc.green + SUM_W'(r_pix.green);
            acc.blue  = acc.blue  + SUM_W'(r_pix.blue);
            acc.count = acc.count + CNT_W'(1);
        end
    end

    assign div_start = (r_state == S_CALC) && r_blk_end;

    mba_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_sum_r  (acc.red),
        .i_sum_g  (acc.green),
        .i_sum_b  (acc.blue),
        .i_count  (acc.count),
        .o_done   (div_done),
        .o_quot_r (q_r),
        .o_quot_g (q_g),
        .o_quot_b (q_b)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (accept) r_state <= S_CALC;
                S_CALC: r_state <= r_blk_end ? S_DIV : S_IDLE;
                S_DIV:  if (div_done) r_state <= S_OUT;
                S_OUT:  if (out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register: holds the finished block until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out.block_col  <= r_cur_col;
            r_out.block_row  <= r_cur_row;
            r_out.block_edge <= bs;
            r_out.avg_red    <= q_r;
            r_out.avg_green  <= q_g;
            r_out.avg_blue   <= q_b;
            r_out.frame_done <= r_frame_end;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mba_pkg::*;

    localparam int MAX_DIM        = 1024;
    localparam int BLOCK_COLS     = 256;
    localparam int SETTLE_CYCLES  = 32;     // divider plus output stage, with slack
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    // block side per phase entry, normal and 600-row screens
    localparam int SIDE_SHORT [PHASES] = '{160, 80, 40, 20, 10, 5};
    localparam int SIDE_TALL  [PHASES] = '{200, 100, 50, 25, 10, 5};

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    t_in               i_data = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    t_out              o_data;
    logic              i_cfg_we = 1'b0;
    logic [CADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    mosaic_block_averager_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // pixels waiting to be offered, block means still to arrive
    t_in  pixel_q [$];
    t_out block_means_q [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned mismatches = 0;

    // ---------------------------------------------------------------
    // Predictor state: registers, scan position, per-column sums
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] cfg_width, cfg_height;
    logic [2:0]       cfg_phase;
    logic             cfg_dir_in;
    int unsigned      scan_x, scan_y;
    logic [SUM_W-1:0] red_sum [BLOCK_COLS];
    logic [SUM_W-1:0] green_sum [BLOCK_COLS];
    logic [SUM_W-1:0] blue_sum [BLOCK_COLS];
    logic [CNT_W-1:0] counted [BLOCK_COLS];

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function automatic int unsigned block_side();
        int unsigned ph;
        int unsigned idx;
        ph  = (cfg_phase > PHASES - 1) ? PHASES - 1 : cfg_phase;
        idx = cfg_dir_in ? ph : PHASES - 1 - ph;
        return (cfg_height == TALL_ROWS) ? SIDE_TALL[idx] : SIDE_SHORT[idx];
    endfunction

    task automatic restart_frame();
        scan_x = 0;
        scan_y = 0;
        for (int i = 0; i < BLOCK_COLS; i++) begin
            red_sum[i]   = '0;
            green_sum[i] = '0;
            blue_sum[i]  = '0;
            counted[i]   = '0;
        end
    endtask

    task automatic apply_register_write(input logic [CADDR_W-1:0] idx,
                                        input logic [CFG_W-1:0] val);
        case (idx)
            CFG_SCREEN_WIDTH:  cfg_width  = val;
            CFG_SCREEN_HEIGHT: cfg_height = val;
            CFG_EFFECT_PHASE:  cfg_phase  = val[2:0];
            CFG_DIRECTION_IN:  cfg_dir_in = val[0];
            default: ;
        endcase
        restart_frame();
    endtask

    // Add one pixel to its column and queue the block means when it closes a block.
    task automatic accumulate_pixel(input t_in px);
        int unsigned w, h, side, x, y, col, row, slot;
        bit          close_x, close_y;
        t_out        res;
        w    = clamp_dim(cfg_width);
        h    = clamp_dim(cfg_height);
        side = block_side();
        x    = (scan_x >= w) ? w - 1 : scan_x;
        y    = (scan_y >= h) ? h - 1 : scan_y;
        col  = x / side;
        row  = y / side;
        slot = col % BLOCK_COLS;

        if (px.in_source) begin
            red_sum[slot]   = red_sum[slot] + SUM_W'(px.red);
            green_sum[slot] = green_sum[slot] + SUM_W'(px.green);
            blue_sum[slot]  = blue_sum[slot] + SUM_W'(px.blue);
            counted[slot]   = counted[slot] + 1'b1;
        end

        // clipped blocks close at the right and bottom screen border
        close_x = ((x % side) == side - 1) || (x == w - 1);
        close_y = ((y % side) == side - 1) || (y == h - 1);
        if (close_x && close_y) begin
            res            = '0;
            res.block_col  = 8'(col);
            res.block_row  = 8'(row);
            res.block_edge = 8'(side);
            if (counted[slot] != 0) begin
                res.avg_red   = 8'(red_sum[slot] / counted[slot]);
                res.avg_green = 8'(green_sum[slot] / counted[slot]);
                res.avg_blue  = 8'(blue_sum[slot] / counted[slot]);
            end
            res.frame_done  = (x == w - 1) && (y == h - 1);
            block_means_q.push_back(res);
            red_sum[slot]   = '0;
            green_sum[slot] = '0;
            blue_sum[slot]  = '0;
            counted[slot]   = '0;
        end

        // advance in raster order, wrap to the next frame at the end
        if (x == w - 1) begin
            scan_x = 0;
            scan_y = (y == h - 1) ? 0 : y + 1;
        end else begin
            scan_x = x + 1;
            scan_y = y;
        end
    endtask

    // Track register writes and accepted pixels on the same edge the block sees them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width  = 11'd800;
            cfg_height = 11'd600;
            cfg_phase  = '0;
            cfg_dir_in = 1'b0;
            restart_frame();
        end else begin
            if (i_cfg_we) apply_register_write(i_cfg_addr, i_cfg_data);
            if (i_valid && o_ready) accumulate_pixel(i_data);
        end
    end

    // ---------------------------------------------------------------
    // Pixel driver: hold the item until accepted, then offer the next
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_data  <= pixel_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result side: random stalls plus the long hold-off on request
    // ---------------------------------------------------------------
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD;
            i_ready      <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (block_means_q.size() == 0) begin
                $error("block result with nothing expected: %p", o_data);
                mismatches++;
            end else begin
                want = block_means_q.pop_front();
                check_field("block_col",  want.block_col,  o_data.block_col);
                check_field("block_row",  want.block_row,  o_data.block_row);
                check_field("block_edge", want.block_edge, o_data.block_edge);
                check_field("avg_red",    want.avg_red,    o_data.avg_red);
                check_field("avg_green",  want.avg_green,  o_data.avg_green);
                check_field("avg_blue",   want.avg_blue,   o_data.avg_blue);
                check_field("frame_done", want.frame_done, o_data.frame_done);
            end
        end
    end

    // End the run when no handshake of any kind happens for too long.
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("** mosaic_block_averager_core: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_in random_pixel();
        t_in px;
        px.red       = random_channel();
        px.green     = random_channel();
        px.blue      = random_channel();
        px.in_source = ($urandom_range(0, 9) != 0);
        return px;
    endfunction

    task automatic send_pixels(input int unsigned n);
        for (int i = 0; i < n; i++) pixel_q.push_back(random_pixel());
    endtask

    // Wait for every pixel taken and every block result back, then let
    // pixels that close no block clear the pipeline.
    task automatic wait_drained();
        while (pixel_q.size() != 0 || i_valid || block_means_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers back to back once the block is idle.
    task automatic configure(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height,
                             input logic [CFG_W-1:0] phase, input logic [CFG_W-1:0] dir_in);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_SCREEN_WIDTH;
        i_cfg_data <= width;
        @(posedge i_clk);
        i_cfg_addr <= CFG_SCREEN_HEIGHT;
        i_cfg_data <= height;
        @(posedge i_clk);
        i_cfg_addr <= CFG_EFFECT_PHASE;
        i_cfg_data <= phase;
        @(posedge i_clk);
        i_cfg_addr <= CFG_DIRECTION_IN;
        i_cfg_data <= dir_in;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int unsigned mode;
        logic [CFG_W-1:0] w, h;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // One-pixel screen: every pixel is a whole block and ends the frame.
        configure(11'd1, 11'd1, 11'd0, 11'd1);
        pixel_q.push_back(t_in'({8'h00, 8'h00, 8'h00, 1'b1}));
        pixel_q.push_back(t_in'({8'hFF, 8'hFF, 8'hFF, 1'b1}));
        pixel_q.push_back(t_in'({8'hFF, 8'hFF, 8'hFF, 1'b0}));  // nothing counted
        pixel_q.push_back(t_in'({8'hAA, 8'h55, 8'hAA, 1'b1}));
        pixel_q.push_back(t_in'({8'h55, 8'hAA, 8'h55, 1'b1}));
        pixel_q.push_back(t_in'({8'h01, 8'h80, 8'hFE, 1'b1}));

        // Zero dimensions act as one; phase above the table saturates.
        configure(11'd0, 11'd0, 11'd7, 11'd0);
        pixel_q.push_back(t_in'({8'hFF, 8'h00, 8'hFF, 1'b1}));
        pixel_q.push_back(t_in'({8'h00, 8'hFF, 8'h00, 1'b1}));

        // Small screen inside one clipped block, mixed source flags.
        configure(11'd7, 11'd2, 11'd1, 11'd1);
        for (int i = 0; i < 14; i++)
            pixel_q.push_back(t_in'({8'(i * 19), 8'(255 - i * 19), 8'(i * 37),
                                     1'(i % 3 != 0)}));

        // Oversized width saturates: full row of the smallest blocks, then wrap.
        configure(11'd2047, 11'd1, 11'd6, 11'd1);
        send_pixels(1030);

        // Oversized height, single column.
        configure(11'd1, 11'd2047, 11'd3, 11'd1);
        send_pixels(90);

        // 600 rows selects the tall table.
        configure(11'd2, 11'd600, 11'd2, 11'd0);
        send_pixels(60);

        // Long hold-off on results while pixels keep coming: fill the block up.
        configure(11'd1, 11'd1, 11'd5, 11'd0);
        hold_requests++;
        send_pixels(60);

        // Random screens under each idling pattern.
        for (int p = 0; p < 12; p++) begin
            mode = p % 4;
            h = ($urandom_range(0, 5) == 0) ? 11'd600 : 11'($urandom_range(1, 12));
            w = (h == 11'd600) ? 11'($urandom_range(1, 3)) : 11'($urandom_range(1, 24));
            configure(w, h, {8'($urandom), 3'($urandom_range(0, 7))},
                      {10'($urandom), 1'($urandom_range(0, 1))});
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            send_pixels($urandom_range(30, 70));
        end

        wait_drained();
        if (mismatches == 0 && block_means_q.size() == 0) begin
            $display("** mosaic_block_averager_core: PASSED **");
        end else begin
            $display("** mosaic_block_averager_core: FAILED **");
        end
        $finish;
    end

endmodule
